// ===== rtl/simplified_aes_cipher_unit_assert.svh =====
// Assertion macros for the S-AES cipher unit.
// SAES_ASSERT checks outside reset; SAES_ASSERT_RST also checks during reset.
`ifndef SIMPLIFIED_AES_CIPHER_UNIT_ASSERT_SVH
`define SIMPLIFIED_AES_CIPHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SAES_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("saes assertion failed");

`define SAES_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("saes reset assertion failed");

`else

`define SAES_ASSERT(lbl, prop)

`define SAES_ASSERT_RST(lbl, prop)

`endif

`endif

// ===== rtl/saes_pkg.sv =====
package saes_pkg;

   typedef struct packed {
      logic        kind;
      logic [15:0] block_in;
      logic [15:0] cipher_key;
   } saes_req_type;

   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   localparam logic [7:0] RCON_ONE = 8'h80;
   localparam logic [7:0] RCON_TWO = 8'h30;

   // x^4 + x + 1, low four bits fold back after a carry out of bit 3
   localparam logic [3:0] GF_POLY_LOW = 4'h3;

   localparam logic [3:0] MIX_FWD_DIAG = 4'h1;
   localparam logic [3:0] MIX_FWD_OFF  = 4'h4;
   localparam logic [3:0] MIX_INV_DIAG = 4'h9;
   localparam logic [3:0] MIX_INV_OFF  = 4'h2;

   localparam logic [3:0] FWD_SBOX [16] = '{
      4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
      4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
   };

   localparam logic [3:0] INV_SBOX [16] = '{
      4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
      4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
   };

endpackage

// ===== rtl/saes_datapath.sv =====
module saes_datapath (
   input  saes_pkg::saes_req_type item,
   output logic [15:0]            block_out
);
   import saes_pkg::*;

   function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
      logic [3:0] acc;
      logic [3:0] x;
      begin
         acc = 4'h0;
         x   = a;
         for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
               acc = acc ^ x;
            end
            x = {x[2:0], 1'b0} ^ (x[3] ? GF_POLY_LOW : 4'h0);
         end
         return acc;
      end
   endfunction

   function automatic logic [15:0] sub_fwd(input logic [15:0] v);
      logic [15:0] r;
      begin
         for (int i = 0; i < 4; i++) begin
            r[4*i +: 4] = FWD_SBOX[v[4*i +: 4]];
         end
         return r;
      end
   endfunction

   function automatic logic [15:0] sub_inv(input logic [15:0] v);
      logic [15:0] r;
      begin
         for (int i = 0; i < 4; i++) begin
            r[4*i +: 4] = INV_SBOX[v[4*i +: 4]];
         end
         return r;
      end
   endfunction

   // swap the second and fourth nibble
   function automatic logic [15:0] shift_rows(input logic [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   function automatic logic [15:0] mix_cols(input logic [15:0] v, input logic [3:0] d,
                                            input logic [3:0] o);
      return {gf_mul(d, v[15:12]) ^ gf_mul(o, v[11:8]),
              gf_mul(o, v[15:12]) ^ gf_mul(d, v[11:8]),
              gf_mul(d, v[7:4])   ^ gf_mul(o, v[3:0]),
              gf_mul(o, v[7:4])   ^ gf_mul(d, v[3:0])};
   endfunction

   function automatic logic [7:0] key_word_mix(input logic [7:0] w);
      return {FWD_SBOX[w[3:0]], FWD_SBOX[w[7:4]]};
   endfunction

   logic [7:0]  w0, w1, w2, w3, w4, w5;
   logic [15:0] rk0, rk1, rk2;
   logic [15:0] enc_a, enc_b, enc_out;
   logic [15:0] dec_a, dec_b, dec_out;

   always_comb begin
      // key schedule
      w0  = item.cipher_key[15:8];
      w1  = item.cipher_key[7:0];
      w2  = w0 ^ RCON_ONE ^ key_word_mix(w1);
      w3  = w2 ^ w1;
      w4  = w2 ^ RCON_TWO ^ key_word_mix(w3);
      w5  = w4 ^ w3;
      rk0 = {w0, w1};
      rk1 = {w2, w3};
      rk2 = {w4, w5};

      enc_a   = shift_rows(sub_fwd(item.block_in ^ rk0));
      enc_b   = mix_cols(enc_a, MIX_FWD_DIAG, MIX_FWD_OFF) ^ rk1;
      enc_out = shift_rows(sub_fwd(enc_b)) ^ rk2;

      dec_a   = sub_inv(shift_rows(item.block_in ^ rk2)) ^ rk1;
      dec_b   = mix_cols(dec_a, MIX_INV_DIAG, MIX_INV_OFF);
      dec_out = sub_inv(shift_rows(dec_b)) ^ rk0;

      block_out = (item.kind == KIND_DECRYPT) ? dec_out : enc_out;
   end

endmodule

// ===== rtl/simplified_aes_cipher_unit.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// request   | in        | req_valid/req_stall| req_kind, req_block_in, req_cipher_key
// response  | out       | rsp_valid/rsp_stall| rsp_block_out
//
// An accepted request is captured in the request register and its result in the response
// register; one request per cycle is sustained while rsp_stall stays low. Both rounds and
// the key schedule run in combinational logic between the two registers.
// Synchronous active-high reset clears both valid bits; payload registers are not reset.
// A stalled response holds the response register; a full request register then holds
// too, and req_stall rises only while it holds an item that cannot move on.
module simplified_aes_cipher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_block_in,
   input  logic [15:0] req_cipher_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_block_out
);
   import saes_pkg::*;

   `include "simplified_aes_cipher_unit_assert.svh"

   // request stage
   logic         in_valid_ff, in_valid_in;
   saes_req_type in_item_ff, in_item_in;

   // response stage
   logic         out_valid_ff, out_valid_in;
   logic [15:0]  block_out_ff, block_out_in;

   logic [15:0]  cipher_result;
   logic         out_free;
   logic         req_accept;

   // response register can take a new value when empty or being drained
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   saes_datapath u_datapath (
      .item      (in_item_ff),
      .block_out (cipher_result)
   );

   always_comb begin
      // advance the request stage whenever it is empty or moving on
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_item_in  = '{kind: req_kind, block_in: req_block_in,
                         cipher_key: req_cipher_key};
      end

      // load the result, drop a taken response, or hold while stalled
      out_valid_in = out_valid_ff;
      block_out_in = block_out_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         block_out_in = cipher_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff   <= in_item_in;
      block_out_ff <= block_out_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block_out = block_out_ff;

   `SAES_ASSERT_RST(a_reset_empties, reset |=> (!in_valid_ff && !out_valid_ff))
   `SAES_ASSERT(a_stall_only_when_full, req_stall |-> (in_valid_ff && out_valid_ff))
   `SAES_ASSERT(a_accept_loads_stage, req_accept |=> in_valid_ff)
   `SAES_ASSERT(a_result_moves, (in_valid_ff && out_free) |=>
                (out_valid_ff && block_out_ff == $past(cipher_result)))

endmodule

// ===== tb/simplified_aes_cipher_unit_test.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the S-AES cipher unit. Every request carries a mode bit, a block
// and a key; the bench computes the expected output block on acceptance and queues it.
// A monitor pops the queue on every accepted response and compares the block.
// The request side inserts random gaps. The response side stalls in random bursts.
// The final phase runs at full rate with neither.
module simplified_aes_cipher_unit_test;
   import saes_pkg::*;

   typedef struct {
      saes_req_type request;
      logic [15:0]  block_out;
   } cipher_expect_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [15:0] req_block_in;
   logic [15:0] req_cipher_key;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_block_out;

   // expected output blocks, oldest first
   cipher_expect_type pending_blocks[$];
   cipher_expect_type oldest_block;

   bit idle_enabled = 1'b0;
   int stall_left = 0;
   int mismatch_count = 0;
   int response_count = 0;
   int encrypt_count = 0;
   int decrypt_count = 0;

   always #4 clock = ~clock;

   simplified_aes_cipher_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_block_in  (req_block_in),
      .req_cipher_key(req_cipher_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_out (rsp_block_out)
   );

   // ---------------------------------------------------------------- cipher predictor

   // GF(16) multiply, reduce by x^4+x+1 after each shift
   function automatic logic [3:0] gf16_times(logic [3:0] a, logic [3:0] b);
      logic [3:0] acc;
      logic [3:0] x;
      acc = 4'h0;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (b[i]) acc ^= x;
         x = {x[2:0], 1'b0} ^ (x[3] ? GF_POLY_LOW : 4'h0);
      end
      return acc;
   endfunction

   function automatic logic [15:0] substitute(logic [15:0] v, logic inverse);
      logic [15:0] r;
      for (int i = 0; i < 4; i++) begin
         r[4*i +: 4] = inverse ? INV_SBOX[v[4*i +: 4]] : FWD_SBOX[v[4*i +: 4]];
      end
      return r;
   endfunction

   // swap the lower-row nibbles of the two columns
   function automatic logic [15:0] swap_rows(logic [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   function automatic logic [15:0] mix_columns(logic [15:0] v, logic [3:0] diag,
                                               logic [3:0] off);
      return {gf16_times(diag, v[15:12]) ^ gf16_times(off, v[11:8]),
              gf16_times(off, v[15:12]) ^ gf16_times(diag, v[11:8]),
              gf16_times(diag, v[7:4]) ^ gf16_times(off, v[3:0]),
              gf16_times(off, v[7:4]) ^ gf16_times(diag, v[3:0])};
   endfunction

   // rotate the two nibbles of a key word, then push both through the forward S-box
   function automatic logic [7:0] key_word_sub(logic [7:0] w);
      logic [15:0] s;
      s = substitute({8'h00, w[3:0], w[7:4]}, 1'b0);
      return s[7:0];
   endfunction

   function automatic logic [15:0] saes_result(logic kind, logic [15:0] blk,
                                               logic [15:0] key);
      logic [7:0]  w2, w3, w4, w5;
      logic [15:0] rk1, rk2, v;
      w2 = key[15:8] ^ RCON_ONE ^ key_word_sub(key[7:0]);
      w3 = w2 ^ key[7:0];
      w4 = w2 ^ RCON_TWO ^ key_word_sub(w3);
      w5 = w4 ^ w3;
      rk1 = {w2, w3};
      rk2 = {w4, w5};
      if (kind == KIND_ENCRYPT) begin
         v = blk ^ key;
         v = swap_rows(substitute(v, 1'b0));
         v = mix_columns(v, MIX_FWD_DIAG, MIX_FWD_OFF) ^ rk1;
         v = swap_rows(substitute(v, 1'b0)) ^ rk2;
      end else begin
         v = blk ^ rk2;
         v = substitute(swap_rows(v), 1'b1) ^ rk1;
         v = mix_columns(v, MIX_INV_DIAG, MIX_INV_OFF);
         v = substitute(swap_rows(v), 1'b1) ^ key;
      end
      return v;
   endfunction

   // ---------------------------------------------------------------- shared tasks

   task automatic report_mismatch(input string what);
      mismatch_count++;
      // cap the log; keep counting
      if (mismatch_count <= 20) $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Present one request and hold it until accepted, then queue its expected block.
   // Call right after a rising edge; valid stays high into the next request.
   task automatic send_request(input logic kind, input logic [15:0] blk,
                               input logic [15:0] key);
      cipher_expect_type entry;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_block_in   <= blk;
      req_cipher_key <= key;
      do @(posedge clock); while (req_stall !== 1'b0);
      entry.request.kind       = kind;
      entry.request.block_in   = blk;
      entry.request.cipher_key = key;
      entry.block_out          = saes_result(kind, blk, key);
      pending_blocks.push_back(entry);
      if (kind == KIND_DECRYPT) decrypt_count++;
      else encrypt_count++;
   endtask

   // drop valid and hold until every queued block has come back
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // Textbook S-AES vector in both directions; also cross-check the predictor itself.
   task automatic test_textbook_vector();
      if (saes_result(KIND_ENCRYPT, 16'h6F6B, 16'hA73B) !== 16'h0738)
         report_mismatch("predictor disagrees with textbook ciphertext");
      if (saes_result(KIND_DECRYPT, 16'h0738, 16'hA73B) !== 16'h6F6B)
         report_mismatch("predictor disagrees with textbook plaintext");
      send_request(KIND_ENCRYPT, 16'h6F6B, 16'hA73B);
      send_request(KIND_DECRYPT, 16'h0738, 16'hA73B);
   endtask

   // All-zero, all-one and alternating blocks and keys in both modes.
   task automatic test_field_extremes();
      logic [15:0] blocks[5] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hAAAA};
      logic [15:0] keys[5]   = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h5555};
      for (int i = 0; i < 5; i++) begin
         send_request(KIND_ENCRYPT, blocks[i], keys[i]);
         send_request(KIND_DECRYPT, blocks[i], keys[i]);
      end
   endtask

   // Encrypt a random block, then decrypt the ciphertext under the same key.
   task automatic test_round_trips(input int pairs);
      logic [15:0] plain, key;
      for (int i = 0; i < pairs; i++) begin
         plain = 16'($urandom);
         key   = 16'($urandom);
         send_request(KIND_ENCRYPT, plain, key);
         send_request(KIND_DECRYPT, saes_result(KIND_ENCRYPT, plain, key), key);
      end
   endtask

   task automatic test_random_requests(input int count);
      for (int i = 0; i < count; i++) begin
         send_request(logic'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
      end
   endtask

   // Let the pipeline run empty mid-stream, then restart it.
   task automatic test_drain_pause();
      test_random_requests(50);
      wait_for_responses();
      test_random_requests(50);
   endtask

   // ---------------------------------------------------------------- response side

   // stall the response channel in random bursts while idling is enabled
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!idle_enabled) stall_left = 0;
         if (stall_left == 0 && idle_enabled && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 6);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // compare every accepted response with the oldest queued block
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_blocks.size() == 0) begin
            report_mismatch($sformatf("response %h with no request outstanding",
                                      rsp_block_out));
         end else begin
            oldest_block = pending_blocks.pop_front();
            response_count++;
            if (rsp_block_out !== oldest_block.block_out)
               report_mismatch($sformatf(
                  "kind %0d block %h key %h: got %h, want %h",
                  oldest_block.request.kind, oldest_block.request.block_in,
                  oldest_block.request.cipher_key, rsp_block_out,
                  oldest_block.block_out));
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= KIND_ENCRYPT;
      req_block_in   <= 16'h0000;
      req_cipher_key <= 16'h0000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed part runs without idling
      test_textbook_vector();
      test_field_extremes();

      idle_enabled = 1'b1;
      test_round_trips(150);
      test_random_requests(400);
      test_drain_pause();

      // close at full rate, no gaps and no stalls
      idle_enabled = 1'b0;
      test_random_requests(150);

      wait_for_responses();
      repeat (8) @(posedge clock);

      $display("Covered %0d encrypt and %0d decrypt requests; %0d responses checked.",
               encrypt_count, decrypt_count, response_count);
      $display("Included textbook vector, field extremes, round trips, a drained pause.");
      if (mismatch_count == 0) begin
         $display("simplified_aes_cipher_unit test passed");
      end else begin
         $display("simplified_aes_cipher_unit test failed");
      end
      $finish;
   end

   // hard limit well past the slowest legal run
   initial begin
      #2_000_000;
      $display("Timeout with %0d responses still outstanding", pending_blocks.size());
      $display("simplified_aes_cipher_unit test failed");
      $finish;
   end

endmodule

// ===== simplified_aes_cipher_unit.f =====
+incdir+rtl
rtl/saes_pkg.sv
rtl/saes_datapath.sv
rtl/simplified_aes_cipher_unit.sv
tb/simplified_aes_cipher_unit_test.sv
